// ===== hw/rtl/sas_pkg.sv =====
// Shared constants for the ascending array sorter.
package sas_pkg;

  localparam int MaxItems = 64;
  localparam int DataW    = 32;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic signed [DataW-1:0] word_t;

endpackage

// ===== hw/rtl/array_sort_ascending_top.sv =====
// Ascending sorter: loads a set of signed words, sorts it in place, streams it out.
//
// Input channel (in_valid_i / in_stall_o): one signed 32-bit value per beat;
// last_i closes the set. While loading, a beat is taken every cycle. Values
// beyond MaxItems are dropped and every result of that set carries overflow_o.
// After the closing beat in_stall_o stays high until the last result is taken.
// Sorting is an insertion sort over one element memory (one write port, one read
// port) with a single signed comparator: each key is read and compared with the
// neighbors to its left, each larger neighbor moves one place right, and the key
// is written where it stops.
// Output channel (out_valid_o / out_stall_i): one sorted value per beat,
// final_res_o on the greatest one. Each result needs a memory read, which starts
// only after the previous result is taken; a stalled result holds until taken.
// Once the final result is taken the block loads the next set in the next cycle.
// Reset (rst_ni low) empties the set and clears the overflow mark; memory
// contents are not cleared, as only written entries are ever read.
module array_sort_ascending_top
  import sas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  word_t       value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output word_t       sorted_value_o,
  output logic        final_res_o,
  output logic        overflow_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_KEY_RD,
    S_KEY_WT,
    S_CMP,
    S_PLACE,
    S_EM_RD,
    S_EM_WT,
    S_EM_HOLD
  } state_e;

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   ovf_q, ovf_d;
  idx_t   k_q, k_d;
  idx_t   pos_q, pos_d;
  idx_t   e_q, e_d;
  word_t  key_q, key_d;
  logic   out_valid_d, final_d;
  word_t  out_value_d;

  // element memory, one write and one registered read per cycle
  word_t  mem [MaxItems];
  word_t  rd_q;
  idx_t   rd_addr;
  logic   mem_we;
  idx_t   mem_wa;
  word_t  mem_wd;

  logic   in_acc, out_acc, full, less;
  cnt_t   cnt_next;

  assign in_acc   = (state_q == S_LOAD) && in_valid_i;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign full     = (count_q == CntW'(MaxItems));
  assign cnt_next = full ? count_q : count_q + 1'b1;
  assign less     = (key_q < rd_q);
  assign in_stall_o = (state_q != S_LOAD);

  // store writes and the read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  // sequencer: load, insertion sort, emit
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    pos_d       = pos_q;
    e_d         = e_q;
    key_d       = key_q;
    out_valid_d = out_valid_o;
    out_value_d = sorted_value_o;
    final_d     = final_res_o;
    mem_we      = 1'b0;
    mem_wa      = count_q[IdxW-1:0];
    mem_wd      = value_i;
    rd_addr     = k_q;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we = 1'b1;
          end
          count_d = cnt_next;
          if (last_i) begin
            k_d = idx_t'(1);
            e_d = '0;
            state_d = (cnt_next >= CntW'(2)) ? S_KEY_RD : S_EM_RD;
          end
        end
      end
      S_KEY_RD: begin
        rd_addr = k_q;
        state_d = S_KEY_WT;
      end
      S_KEY_WT: begin
        // take the key, fetch its left neighbor
        key_d   = rd_q;
        pos_d   = k_q;
        rd_addr = k_q - 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        rd_addr = pos_q - idx_t'(2);
        if (less) begin
          // shift the larger neighbor right
          mem_we = 1'b1;
          mem_wa = pos_q;
          mem_wd = rd_q;
          pos_d  = pos_q - 1'b1;
          if (pos_q == idx_t'(1)) begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_we = 1'b1;
        mem_wa = pos_q;
        mem_wd = key_q;
        k_d    = k_q + 1'b1;
        if (({1'b0, k_q} + CntW'(1)) == count_q) begin
          state_d = S_EM_RD;
        end else begin
          state_d = S_KEY_RD;
        end
      end
      S_EM_RD: begin
        rd_addr = e_q;
        state_d = S_EM_WT;
      end
      S_EM_WT: begin
        out_valid_d = 1'b1;
        out_value_d = rd_q;
        final_d     = (({1'b0, e_q} + CntW'(1)) == count_q);
        state_d     = S_EM_HOLD;
      end
      S_EM_HOLD: begin
        // hold the beat until taken
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (final_res_o) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_o <= 1'b0;
      final_res_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_o <= out_valid_d;
      final_res_o <= final_d;
    end
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    k_q            <= k_d;
    pos_q          <= pos_d;
    e_q            <= e_d;
    key_q          <= key_d;
    sorted_value_o <= out_value_d;
  end

  assign overflow_o = ovf_q;

endmodule

// ===== hw/rtl/sas_checker.sv =====
// Port-level checks for the ascending sorter, bound to the top level.
module sas_checker
  import sas_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_stall_o,
  input logic  last_i,
  input logic  out_valid_o,
  input logic  out_stall_i,
  input word_t sorted_value_o,
  input logic  final_res_o,
  input logic  overflow_o
);

  // a stalled result beat stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_value_o) &&
      $stable(final_res_o) && $stable(overflow_o))
    else $error("result beat dropped or changed while stalled");

  // no input taken while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during emission");

  // a closing beat blocks input; a loading beat does not
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input open after closing beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_i |=> !in_stall_o && !out_valid_o)
    else $error("loading beat stalled input or produced a result");

  // after the final result is taken the next set may load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && final_res_o |=> !in_stall_o && !out_valid_o)
    else $error("block not ready after final result");

endmodule

bind array_sort_ascending_top sas_checker u_sas_checker (.*);
